FILE: rtl/decimal_scale_align_round_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for decimal_scale_align_round
// Implication checks, sampled on the rising clock edge, off during reset.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_SCALE_ALIGN_ROUND_ASSERT_SVH
`define DECIMAL_SCALE_ALIGN_ROUND_ASSERT_SVH

`ifndef SYNTH

// antecedent implies consequent in the same cycle
`define DSAR_ASSERT_SAME(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dsar check failed");

// antecedent implies consequent in the next cycle
`define DSAR_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dsar check failed");

`else

`define DSAR_ASSERT_SAME(name, clk, rst_n, ante, cons)
`define DSAR_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/dsar_pkg.sv
// ----------------------------------------------------------------------------
// dsar_pkg
// Shared constants and control/status types of the decimal scale aligner.
// ----------------------------------------------------------------------------
package dsar_pkg;

    // field widths
    localparam int FULL_BITS  = 96;
    localparam int LOW_BITS   = 64;
    localparam int HIGH_BITS  = 32;
    localparam int SCALE_BITS = 5;

    // one digit of the serial datapath
    localparam int DIG_BITS   = 16;
    localparam int REM_BITS   = 4;
    localparam int VAL_BITS   = DIG_BITS + REM_BITS;

    // x / 10 == (x * DIV_MAGIC) >> DIV_SHIFT for x < 2^22
    localparam int DIV_SHIFT  = 23;
    localparam logic [VAL_BITS-1:0] DIV_MAGIC = 20'd838861;

    // rounding midpoint of a decimal remainder
    localparam logic [REM_BITS-1:0] HALF_DIGIT = 4'd5;

    // engine command
    typedef struct packed {
        logic load;
        logic start;
        logic div;
        logic inc;
    } eng_cmd_t;

    // engine status
    typedef struct packed {
        logic                done;
        logic                ovf;
        logic [REM_BITS-1:0] rem;
    } eng_sts_t;

endpackage

FILE: rtl/dsar_engine.sv
// ----------------------------------------------------------------------------
// dsar_engine
// Digit-serial x10 / div10 unit: the mantissa rotates through a 16-bit
// digit slot, one digit per cycle, with a 4-bit carry or remainder.
// ----------------------------------------------------------------------------
module dsar_engine
    import dsar_pkg::*;
#(
    parameter int MANT_BITS = 96
)
(
    input  logic                                                   clk,
    input  logic                                                   rst_n,
    input  eng_cmd_t                                               cmd,
    input  logic [((MANT_BITS+DIG_BITS-1)/DIG_BITS)*DIG_BITS-1:0] load_val,
    output logic [((MANT_BITS+DIG_BITS-1)/DIG_BITS)*DIG_BITS-1:0] val,
    output eng_sts_t                                               sts
);

    localparam int NDIG  = (MANT_BITS + DIG_BITS - 1) / DIG_BITS;
    localparam int W     = NDIG * DIG_BITS;
    localparam int CNT_W = $clog2(NDIG);
    localparam logic [W-1:0] MASK = {W{1'b1}} >> (W - MANT_BITS);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(NDIG - 1);

    logic [W-1:0]          x_reg, x_next;
    logic [W-1:0]          t_reg, t_next;
    logic [REM_BITS-1:0]   acc_reg, acc_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  div_reg, div_next;
    logic                  done_reg, done_next;
    logic                  ovf_reg, ovf_next;

    logic [DIG_BITS-1:0]   lo_dig, hi_dig, q_dig;
    logic [VAL_BITS-1:0]   prod_m, val_d, q10, rem_d;
    logic [2*VAL_BITS-1:0] prod_d;
    logic [W-1:0]          x_rot_r, t_shift;

    // multiply digit: least significant first
    always_comb
    begin
        lo_dig  = x_reg[DIG_BITS-1:0];
        prod_m  = (VAL_BITS'(lo_dig) << 3) + (VAL_BITS'(lo_dig) << 1)
                  + VAL_BITS'(acc_reg);
        x_rot_r = {lo_dig, x_reg[W-1:DIG_BITS]};
        t_shift = {prod_m[DIG_BITS-1:0], t_reg[W-1:DIG_BITS]};
    end

    // divide digit: most significant first, reciprocal multiply
    always_comb
    begin
        hi_dig = x_reg[W-1:W-DIG_BITS];
        val_d  = {acc_reg, hi_dig};
        prod_d = (2*VAL_BITS)'(val_d) * (2*VAL_BITS)'(DIV_MAGIC);
        q_dig  = prod_d[DIV_SHIFT +: DIG_BITS];
        q10    = (VAL_BITS'(q_dig) << 3) + (VAL_BITS'(q_dig) << 1);
        rem_d  = val_d - q10;
    end

    // next state
    always_comb
    begin
        x_next    = x_reg;
        t_next    = t_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        div_next  = div_reg;
        done_next = 1'b0;
        ovf_next  = ovf_reg;
        if (cmd.load)
        begin
            x_next = load_val;
        end
        else if (cmd.inc)
        begin
            x_next = (x_reg + W'(1)) & MASK;
        end
        else if (cmd.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            acc_next  = '0;
            div_next  = cmd.div;
            ovf_next  = 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
            if (div_reg)
            begin
                x_next   = {x_reg[W-DIG_BITS-1:0], q_dig};
                acc_next = rem_d[REM_BITS-1:0];
            end
            else
            begin
                x_next   = x_rot_r;
                t_next   = t_shift;
                acc_next = prod_m[VAL_BITS-1:DIG_BITS];
            end
            if (cnt_reg == LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (!div_reg)
                begin
                    // keep the old value when the product leaves the field
                    ovf_next = (prod_m[VAL_BITS-1:DIG_BITS] != '0)
                               || ((t_shift & ~MASK) != '0);
                    if (!ovf_next)
                    begin
                        x_next = t_shift;
                    end
                end
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            div_reg  <= 1'b0;
            done_reg <= 1'b0;
            ovf_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            div_reg  <= div_next;
            done_reg <= done_next;
            ovf_reg  <= ovf_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        t_reg   <= t_next;
        acc_reg <= acc_next;
    end

    assign val      = x_reg;
    assign sts.done = done_reg;
    assign sts.ovf  = ovf_reg;
    assign sts.rem  = acc_reg;

endmodule

FILE: rtl/decimal_scale_align_round.sv
// ----------------------------------------------------------------------------
// decimal_scale_align_round
// Brings two decimal operands (mantissa, sign, power-of-ten scale) to one
// common scale: x10 on the smaller-scale operand, then div10 with
// round-half-even on the other.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall carries both operands; output channel
//   out_valid/out_stall carries both aligned operands. A transfer happens
//   on a clock edge with valid high and stall low.
//   One operand pair is worked at a time. Each x10 or div10 step runs the
//   mantissa through the digit-serial engine, 16 bits per cycle, over NDIG
//   digits, NDIG = ceil(MANT_BITS/16) (6 at 96 bits). A scale gap of k is
//   closed by x10 steps on the smaller-scale operand; if one overflows,
//   the scale-up stops and div10 steps on the other operand close the rest,
//   plus an increment step when the last division rounds up. The next pair
//   can be taken in the cycle after a result is registered.
//   A finished result sits in the output register; the next pair is taken
//   while it waits. While out_stall stays high a second finished result
//   waits inside and in_stall stays high until the output register frees.
//   Reset empties the output register and returns the controller to idle.
// ----------------------------------------------------------------------------
`include "decimal_scale_align_round_assert.svh"

module decimal_scale_align_round
    import dsar_pkg::*;
#(
    parameter int MANT_BITS = 96,
    parameter int MAX_SCALE = 28
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [LOW_BITS-1:0]   a_mant_low,
    input  logic [HIGH_BITS-1:0]  a_mant_high,
    input  logic [SCALE_BITS-1:0] a_scale,
    input  logic                  a_negative,
    input  logic [LOW_BITS-1:0]   b_mant_low,
    input  logic [HIGH_BITS-1:0]  b_mant_high,
    input  logic [SCALE_BITS-1:0] b_scale,
    input  logic                  b_negative,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [LOW_BITS-1:0]   a_out_low,
    output logic [HIGH_BITS-1:0]  a_out_high,
    output logic [SCALE_BITS-1:0] a_out_scale,
    output logic                  a_out_negative,
    output logic [LOW_BITS-1:0]   b_out_low,
    output logic [HIGH_BITS-1:0]  b_out_high,
    output logic [SCALE_BITS-1:0] b_out_scale,
    output logic                  b_out_negative
);

    localparam int NDIG = (MANT_BITS + DIG_BITS - 1) / DIG_BITS;
    localparam int W    = NDIG * DIG_BITS;
    localparam logic [SCALE_BITS-1:0] SMAX = SCALE_BITS'(MAX_SCALE);

    typedef enum logic [3:0] {
        IDLE,
        START,
        MUL_CHK,
        MUL_WAIT,
        MUL_END,
        DIV_CHK,
        DIV_WAIT,
        ROUND,
        DIV_END,
        FIN
    } state_t;

    state_t                state_reg, state_next;
    logic [W-1:0]          a_m_reg, a_m_next, b_m_reg, b_m_next;
    logic [SCALE_BITS-1:0] sa_reg, sa_next, sb_reg, sb_next;
    logic [SCALE_BITS-1:0] s_small_reg, s_small_next, s_large_reg, s_large_next;
    logic                  na_reg, na_next, nb_reg, nb_next;
    logic                  a_small_reg, a_small_next;
    logic                  sticky_reg, sticky_next;
    logic                  out_valid_reg, out_valid_next;
    logic [FULL_BITS-1:0]  a_res_reg, a_res_next, b_res_reg, b_res_next;
    logic [SCALE_BITS-1:0] scale_o_reg, scale_o_next;
    logic                  na_o_reg, na_o_next, nb_o_reg, nb_o_next;

    logic [FULL_BITS-1:0]  a_in_full, b_in_full;
    logic [W-1:0]          load_val, eng_val;
    eng_cmd_t              cmd;
    eng_sts_t              sts;
    logic                  last_div, round_up;

    dsar_engine #(
        .MANT_BITS (MANT_BITS)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .load_val (load_val),
        .val      (eng_val),
        .sts      (sts)
    );

    assign a_in_full = {a_mant_high, a_mant_low};
    assign b_in_full = {b_mant_high, b_mant_low};

    // round half to even on the final division
    assign last_div = (s_large_reg - SCALE_BITS'(1)) == s_small_reg;
    assign round_up = last_div && ((sts.rem > HALF_DIGIT)
                      || ((sts.rem == HALF_DIGIT) && (sticky_reg || eng_val[0])));

    // controller
    always_comb
    begin
        state_next     = state_reg;
        a_m_next       = a_m_reg;
        b_m_next       = b_m_reg;
        sa_next        = sa_reg;
        sb_next        = sb_reg;
        s_small_next   = s_small_reg;
        s_large_next   = s_large_reg;
        na_next        = na_reg;
        nb_next        = nb_reg;
        a_small_next   = a_small_reg;
        sticky_next    = sticky_reg;
        out_valid_next = out_valid_reg && out_stall;
        a_res_next     = a_res_reg;
        b_res_next     = b_res_reg;
        scale_o_next   = scale_o_reg;
        na_o_next      = na_o_reg;
        nb_o_next      = nb_o_reg;
        cmd            = '0;
        load_val       = a_small_reg ? b_m_reg : a_m_reg;
        unique case (state_reg)
            IDLE:
            begin
                if (in_valid)
                begin
                    a_m_next   = W'(a_in_full[MANT_BITS-1:0]);
                    b_m_next   = W'(b_in_full[MANT_BITS-1:0]);
                    sa_next    = (a_scale > SMAX) ? SMAX : a_scale;
                    sb_next    = (b_scale > SMAX) ? SMAX : b_scale;
                    na_next    = a_negative;
                    nb_next    = b_negative;
                    state_next = START;
                end
            end
            START:
            begin
                if (sa_reg == sb_reg)
                begin
                    state_next = FIN;
                end
                else
                begin
                    a_small_next = sa_reg < sb_reg;
                    s_small_next = (sa_reg < sb_reg) ? sa_reg : sb_reg;
                    s_large_next = (sa_reg < sb_reg) ? sb_reg : sa_reg;
                    cmd.load     = 1'b1;
                    load_val     = (sa_reg < sb_reg) ? a_m_reg : b_m_reg;
                    state_next   = MUL_CHK;
                end
            end
            MUL_CHK:
            begin
                if (s_small_reg < s_large_reg)
                begin
                    cmd.start  = 1'b1;
                    state_next = MUL_WAIT;
                end
                else
                begin
                    state_next = MUL_END;
                end
            end
            MUL_WAIT:
            begin
                if (sts.done)
                begin
                    if (!sts.ovf)
                    begin
                        s_small_next = s_small_reg + SCALE_BITS'(1);
                        state_next   = MUL_CHK;
                    end
                    else
                    begin
                        state_next = MUL_END;
                    end
                end
            end
            MUL_END:
            begin
                if (a_small_reg)
                begin
                    a_m_next = eng_val;
                end
                else
                begin
                    b_m_next = eng_val;
                end
                cmd.load    = 1'b1;
                sticky_next = 1'b0;
                state_next  = DIV_CHK;
            end
            DIV_CHK:
            begin
                if (s_large_reg > s_small_reg)
                begin
                    cmd.start  = 1'b1;
                    cmd.div    = 1'b1;
                    state_next = DIV_WAIT;
                end
                else
                begin
                    state_next = DIV_END;
                end
            end
            DIV_WAIT:
            begin
                if (sts.done)
                begin
                    s_large_next = s_large_reg - SCALE_BITS'(1);
                    sticky_next  = sticky_reg || (sts.rem != '0);
                    state_next   = round_up ? ROUND : DIV_CHK;
                end
            end
            ROUND:
            begin
                cmd.inc    = 1'b1;
                state_next = DIV_CHK;
            end
            DIV_END:
            begin
                if (a_small_reg)
                begin
                    b_m_next = eng_val;
                end
                else
                begin
                    a_m_next = eng_val;
                end
                state_next = FIN;
            end
            FIN:
            begin
                // hand off to the output register once it is free
                if (!out_valid_reg || !out_stall)
                begin
                    a_res_next     = FULL_BITS'(a_m_reg);
                    b_res_next     = FULL_BITS'(b_m_reg);
                    scale_o_next   = (sa_reg == sb_reg) ? sa_reg : s_small_reg;
                    na_o_next      = na_reg;
                    nb_o_next      = nb_reg;
                    out_valid_next = 1'b1;
                    state_next     = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            out_valid_reg <= 1'b0;
            a_m_reg       <= '0;
            b_m_reg       <= '0;
            sa_reg        <= '0;
            sb_reg        <= '0;
            s_small_reg   <= '0;
            s_large_reg   <= '0;
            na_reg        <= 1'b0;
            nb_reg        <= 1'b0;
            a_small_reg   <= 1'b0;
            sticky_reg    <= 1'b0;
            a_res_reg     <= '0;
            b_res_reg     <= '0;
            scale_o_reg   <= '0;
            na_o_reg      <= 1'b0;
            nb_o_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            a_m_reg       <= a_m_next;
            b_m_reg       <= b_m_next;
            sa_reg        <= sa_next;
            sb_reg        <= sb_next;
            s_small_reg   <= s_small_next;
            s_large_reg   <= s_large_next;
            na_reg        <= na_next;
            nb_reg        <= nb_next;
            a_small_reg   <= a_small_next;
            sticky_reg    <= sticky_next;
            a_res_reg     <= a_res_next;
            b_res_reg     <= b_res_next;
            scale_o_reg   <= scale_o_next;
            na_o_reg      <= na_o_next;
            nb_o_reg      <= nb_o_next;
        end
    end

    // port drive
    assign in_stall       = (state_reg != IDLE);
    assign out_valid      = out_valid_reg;
    assign a_out_low      = a_res_reg[LOW_BITS-1:0];
    assign a_out_high     = a_res_reg[FULL_BITS-1:LOW_BITS];
    assign a_out_scale    = scale_o_reg;
    assign a_out_negative = na_o_reg;
    assign b_out_low      = b_res_reg[LOW_BITS-1:0];
    assign b_out_high     = b_res_reg[FULL_BITS-1:LOW_BITS];
    assign b_out_scale    = scale_o_reg;
    assign b_out_negative = nb_o_reg;

    // checks
    `DSAR_ASSERT_SAME(a_div_gap, clk, rst_n, state_reg == DIV_WAIT, s_large_reg > s_small_reg)
    `DSAR_ASSERT_SAME(a_scale_max, clk, rst_n, out_valid, a_out_scale <= SMAX)
    `DSAR_ASSERT_NEXT(a_mul_step, clk, rst_n,
                      state_reg == MUL_WAIT && sts.done && !sts.ovf,
                      s_small_reg == $past(s_small_reg) + SCALE_BITS'(1))
    `DSAR_ASSERT_SAME(a_round_last, clk, rst_n, state_reg == ROUND, s_large_reg == s_small_reg)

endmodule
